// ----- hdl/psw3d_pkg.sv -----
`default_nettype none
// ============================================================================
// psw3d_pkg - shared types, constants and arithmetic for the shape weights
// Fixed-point formats, kernel coefficients in Q32 and the Q32 multiplier
// with round to nearest, ties away from zero.
// ============================================================================
package psw3d_pkg;

    // Intermediate format: Q32 fractional bits
    localparam int Q     = 32;
    // Signed width of a Horner partial value (|t| < 16)
    localparam int T_W   = 37;
    // Unsigned width of u, u*u and u^3 (all below 16)
    localparam int U_W   = 36;
    // Width of the product of all three weights
    localparam int ALL_W = 31;

    // Kernel coefficients, exact in Q32
    localparam logic signed [T_W-1:0] K_A   = T_W'(64'd15  << 22);
    localparam logic signed [T_W-1:0] K_B   = T_W'(64'd15  << 25);
    localparam logic signed [T_W-1:0] K_C   = T_W'(64'd49  << 25);
    localparam logic signed [T_W-1:0] K_D   = T_W'(64'd21  << 27);
    localparam logic signed [T_W-1:0] K_E   = T_W'(64'd35  << 26);
    localparam logic signed [T_W-1:0] K_G   = T_W'(64'd7   << 28);
    localparam logic signed [T_W-1:0] K_H   = T_W'(64'd175 << 24);
    localparam logic signed [T_W-1:0] K_K   = T_W'(64'd105 << 25);
    localparam logic signed [T_W-1:0] K_M   = T_W'(64'd337 << 23);
    localparam logic signed [T_W-1:0] ONE_Q = T_W'(64'd1   << 32);

    // Q32 x Q32 -> Q32, sign-magnitude, round to nearest, ties away from zero
    function automatic logic signed [T_W-1:0] mulq(
        input logic signed [T_W-1:0] a,
        input logic        [U_W-1:0] b
    );
        logic [T_W-1:0]     mag;
        logic [T_W+U_W-1:0] prod;
        logic [T_W-1:0]     r;
        mag  = a[T_W-1] ? T_W'(-a) : T_W'(a);
        prod = {{U_W{1'b0}}, mag} * {{T_W{1'b0}}, b};
        r    = prod[Q+T_W-1:Q] + T_W'(prod[Q-1]);
        mulq = a[T_W-1] ? -signed'(r) : signed'(r);
    endfunction

endpackage : psw3d_pkg
`default_nettype wire

// ----- hdl/psw3d_if.sv -----
`default_nettype none
// ============================================================================
// psw3d_if - valid/ready channels of the shape weight block
// Input channel carries the three axis offsets, output channel the three
// axis weights and their product.
// ============================================================================
interface psw3d_in_if #(
    parameter int FRAC_BITS = 16
);
    localparam int IN_W = FRAC_BITS + 3;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] off_x;
    logic signed [IN_W-1:0] off_y;
    logic signed [IN_W-1:0] off_z;

    modport source (output valid, output off_x, output off_y, output off_z, input ready);
    modport sink   (input valid, input off_x, input off_y, input off_z, output ready);
endinterface : psw3d_in_if

interface psw3d_out_if import psw3d_pkg::*; #(
    parameter int FRAC_BITS = 16
);
    localparam int W_W = FRAC_BITS + 1;

    logic                    valid;
    logic                    ready;
    logic signed [W_W-1:0]   weight_x;
    logic signed [W_W-1:0]   weight_y;
    logic signed [W_W-1:0]   weight_z;
    logic signed [ALL_W-1:0] weight_all;

    modport source (output valid, output weight_x, output weight_y, output weight_z,
                    output weight_all, input ready);
    modport sink   (input valid, input weight_x, input weight_y, input weight_z,
                    input weight_all, output ready);
endinterface : psw3d_out_if
`default_nettype wire

// ----- hdl/psw3d_kernel.sv -----
`default_nettype none
// ============================================================================
// psw3d_kernel - eight-stage pipeline for one axis weight
// Evaluates the piecewise degree-8 kernel by Horner's rule in stages 2 to 7,
// then rounds, saturates to the weight format and zeroes it outside support.
// ============================================================================
module psw3d_kernel import psw3d_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [FRAC_BITS+2:0] x,
    output logic signed [FRAC_BITS:0]   w
);
    localparam int IN_W = FRAC_BITS + 3;
    localparam int W_W  = FRAC_BITS + 1;
    localparam int SH   = Q - FRAC_BITS;

    localparam logic signed [IN_W-1:0] ONE_X = IN_W'(1) << FRAC_BITS;
    localparam logic signed [IN_W-1:0] TWO_X = IN_W'(2) << FRAC_BITS;
    localparam logic signed [T_W-1:0]  W_HI  = T_W'((64'sd1 <<< (W_W - 1)) - 64'sd1);
    localparam logic signed [T_W-1:0]  W_LO  = -W_HI - T_W'(1);

    // per-stage registers: u, s, u^3, piece select, kill, partial value
    logic [U_W-1:0]          u1_reg, u2_reg, u3_reg, u4_reg, u5_reg, u6_reg;
    logic [U_W-1:0]          s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    logic [U_W-1:0]          c3_reg, c4_reg, c5_reg;
    logic [6:1]              outer_reg;
    logic [7:1]              kill_reg;
    logic signed [T_W-1:0]   t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic signed [W_W-1:0]   w_reg;

    // stage 1: range check, piece choice, magnitude into Q32
    logic [IN_W-1:0]         xmag;
    logic [U_W-1:0]          u1_next;
    logic                    outer_next;
    logic                    kill_next;

    always_comb
    begin
        xmag       = x[IN_W-1] ? IN_W'(-x) : IN_W'(x);
        u1_next    = {{(U_W-IN_W){1'b0}}, xmag} << SH;
        outer_next = (x > ONE_X) || (x <= -ONE_X);
        kill_next  = (x > TWO_X) || (x <= -TWO_X);
    end

    // stages 2..7: Horner chain with shared constants per piece
    logic signed [T_W-1:0]   t2_next, t3_next, t4_next, t5_next, t6_next, t7_next;
    logic [U_W-1:0]          s2_next, c3_next;
    logic signed [T_W-1:0]   s2_full, c3_full;
    logic [U_W-1:0]          m6, m7;

    always_comb
    begin
        t2_next = mulq(outer_reg[1] ? K_A : -K_A, u1_reg) - K_B;
        s2_full = mulq(signed'({1'b0, u1_reg}), u1_reg);
        s2_next = s2_full[U_W-1:0];

        t3_next = mulq(t2_reg, u2_reg) + (outer_reg[2] ? K_C : K_G);
        c3_full = mulq(signed'({1'b0, s2_reg}), u2_reg);
        c3_next = c3_full[U_W-1:0];

        t4_next = mulq(t3_reg, u3_reg) - K_D;
        t5_next = mulq(t4_reg, u4_reg) + (outer_reg[4] ? K_E : K_H);

        m6      = outer_reg[5] ? c5_reg : s5_reg;
        t6_next = mulq(t5_reg, m6) - (outer_reg[5] ? ONE_Q : K_K);

        m7      = outer_reg[6] ? u6_reg : s6_reg;
        t7_next = mulq(t6_reg, m7) + (outer_reg[6] ? ONE_Q : K_M);
    end

    // stage 8: round to weight format, saturate, zero outside support
    logic [T_W-1:0]          tmag;
    logic [T_W-1:0]          rmag;
    logic signed [T_W-1:0]   rval;
    logic signed [W_W-1:0]   w_next;

    always_comb
    begin
        tmag = t7_reg[T_W-1] ? T_W'(-t7_reg) : T_W'(t7_reg);
        rmag = (tmag >> SH) + T_W'(tmag[SH-1]);
        rval = t7_reg[T_W-1] ? -signed'(rmag) : signed'(rmag);
        if (kill_reg[7])
            w_next = '0;
        else if (rval > W_HI)
            w_next = W_HI[W_W-1:0];
        else if (rval < W_LO)
            w_next = W_LO[W_W-1:0];
        else
            w_next = rval[W_W-1:0];
    end

    // pipeline registers, all advance together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg    <= u1_next;
            u2_reg    <= u1_reg;
            u3_reg    <= u2_reg;
            u4_reg    <= u3_reg;
            u5_reg    <= u4_reg;
            u6_reg    <= u5_reg;
            s2_reg    <= s2_next;
            s3_reg    <= s2_reg;
            s4_reg    <= s3_reg;
            s5_reg    <= s4_reg;
            s6_reg    <= s5_reg;
            c3_reg    <= c3_next;
            c4_reg    <= c3_reg;
            c5_reg    <= c4_reg;
            outer_reg <= {outer_reg[5:1], outer_next};
            kill_reg  <= {kill_reg[6:1], kill_next};
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            t4_reg    <= t4_next;
            t5_reg    <= t5_next;
            t6_reg    <= t6_next;
            t7_reg    <= t7_next;
            w_reg     <= w_next;
        end
    end

    assign w = w_reg;

endmodule : psw3d_kernel
`default_nettype wire

// ----- hdl/particle_shape_weight_3d.sv -----
`default_nettype none
// ============================================================================
// particle_shape_weight_3d - smooth degree-8 particle shape weights
// Three axis kernel pipelines followed by a two-stage weight product.
// ============================================================================
// Usage:
//   offs    : input words with off_x/off_y/off_z, signed, FRAC_BITS fraction.
//   weights : output words with weight_x/y/z (FRAC_BITS fraction) and
//             weight_all (30 fraction bits, saturated to 31 bits).
//   Each accepted word produces exactly one output word, in order.
//   The pipeline has 8 stages in each axis kernel (Horner multiplies in
//   stages 2 to 7) plus 2 stages for the product.
//   Throughput is one word per cycle while the receiver takes the output;
//   every stage holds one word and the last stage is the output register.
//   When the receiver stalls the whole pipeline freezes, offs.ready drops
//   only while the output register holds a word that is not taken, so no
//   word is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty and ready after it.
// ============================================================================
module particle_shape_weight_3d import psw3d_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    psw3d_in_if.sink     offs,
    psw3d_out_if.source  weights
);
    localparam int W_W     = FRAC_BITS + 1;
    localparam int KER_LAT = 8;
    localparam int LAT     = KER_LAT + 2;

    localparam logic signed [63:0] ALL_HI = (64'sd1 <<< (ALL_W - 1)) - 64'sd1;
    localparam logic signed [63:0] ALL_LO = -ALL_HI - 64'sd1;

    // signed shift right by 30, round to nearest, ties away from zero
    function automatic logic signed [63:0] rshr30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag    = v[63] ? 64'(-v) : 64'(v);
        r      = (mag >> 30) + 64'(mag[29]);
        rshr30 = v[63] ? -signed'(r) : signed'(r);
    endfunction

    logic [LAT-1:0] vld_reg;
    logic           adv;

    // global advance: move when the output register is empty or taken
    assign adv        = !vld_reg[LAT-1] || weights.ready;
    assign offs.ready = adv;

    // axis kernels
    logic signed [W_W-1:0] wx_k, wy_k, wz_k;

    psw3d_kernel #(.FRAC_BITS(FRAC_BITS)) u_kx (
        .clk (clk), .en (adv), .x (offs.off_x), .w (wx_k)
    );
    psw3d_kernel #(.FRAC_BITS(FRAC_BITS)) u_ky (
        .clk (clk), .en (adv), .x (offs.off_y), .w (wy_k)
    );
    psw3d_kernel #(.FRAC_BITS(FRAC_BITS)) u_kz (
        .clk (clk), .en (adv), .x (offs.off_z), .w (wz_k)
    );

    // stage 9: wx*wy scaled to Q30 and rounded
    logic signed [2*W_W-1:0] pxy;
    logic signed [63:0]      pxy_q60;
    logic signed [63:0]      p1_full;
    logic signed [31:0]      p1_next;
    logic signed [31:0]      p1_reg;
    logic signed [W_W-1:0]   wx9_reg, wy9_reg, wz9_reg;

    always_comb
    begin
        pxy     = wx_k * wy_k;
        pxy_q60 = 64'(pxy) <<< (60 - 2 * FRAC_BITS);
        p1_full = rshr30(pxy_q60);
        p1_next = p1_full[31:0];
    end

    // stage 10: times wz in Q30, rounded and saturated
    logic signed [31:0]      wzs;
    logic signed [63:0]      pall;
    logic signed [63:0]      pall_r;
    logic signed [ALL_W-1:0] all_next;
    logic signed [ALL_W-1:0] all_reg;
    logic signed [W_W-1:0]   wx_reg, wy_reg, wz_reg;

    always_comb
    begin
        wzs    = 32'(wz9_reg) <<< (30 - FRAC_BITS);
        pall   = 64'(p1_reg) * 64'(wzs);
        pall_r = rshr30(pall);
        if (pall_r > ALL_HI)
            all_next = ALL_HI[ALL_W-1:0];
        else if (pall_r < ALL_LO)
            all_next = ALL_LO[ALL_W-1:0];
        else
            all_next = pall_r[ALL_W-1:0];
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], offs.valid};
    end

    // product stage and output registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= p1_next;
            wx9_reg <= wx_k;
            wy9_reg <= wy_k;
            wz9_reg <= wz_k;
            wx_reg  <= wx9_reg;
            wy_reg  <= wy9_reg;
            wz_reg  <= wz9_reg;
            all_reg <= all_next;
        end
    end

    assign weights.valid      = vld_reg[LAT-1];
    assign weights.weight_x   = wx_reg;
    assign weights.weight_y   = wy_reg;
    assign weights.weight_z   = wz_reg;
    assign weights.weight_all = all_reg;

endmodule : particle_shape_weight_3d
`default_nettype wire
